// ===== hw/rtl/sdq_pkg.sv =====
// sdq_pkg: shared types and constants for the sleep delta queue.
// Depends on nothing; imported by every other file of the block.
package sdq_pkg;

    localparam int unsigned TASK_W  = 4;
    localparam int unsigned DELTA_W = 32;

    // Input mode codes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // One queue entry: task id and delta ticks after the entry before it.
    // The token of an add travelling along the chain uses the same layout,
    // with the delta field holding the ticks still to place.
    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [DELTA_W-1:0] delta;
    } t_entry;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic here;     // add token sits in this cell
        logic insert;   // token settles in this cell this cycle
        logic shift_r;  // take the left neighbour's entry (make room)
        logic shift_l;  // take the right neighbour's entry (head leaves)
        logic dec;      // count this entry's delta down by one
    } t_cell_ctl;

endpackage

// ===== hw/rtl/sdq_in_if.sv =====
// sdq_in_if: input channel of the sleep delta queue (valid/ready plus payload).
// Depends on sdq_pkg for field widths.
interface sdq_in_if;
    import sdq_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [TASK_W-1:0]  task_id;
    logic [DELTA_W-1:0] sleep_ticks;

    modport source (output valid, output mode, output task_id, output sleep_ticks,
                    input ready);
    modport sink   (input valid, input mode, input task_id, input sleep_ticks,
                    output ready);
endinterface

// ===== hw/rtl/sdq_out_if.sv =====
// sdq_out_if: result channel of the sleep delta queue (valid/ready plus payload).
// Depends on sdq_pkg for field widths.
interface sdq_out_if;
    import sdq_pkg::*;

    logic              valid;
    logic              ready;
    logic [TASK_W-1:0] woken_task;
    logic              last_woken;
    logic              dropped;

    modport source (output valid, output woken_task, output last_woken,
                    output dropped, input ready);
    modport sink   (input valid, input woken_task, input last_woken,
                    input dropped, output ready);
endinterface

// ===== hw/rtl/sdq_cell.sv =====
// sdq_cell: one slot of the delta list chain, holding an entry and the add token.
// Depends on sdq_pkg; instantiated once per slot by sleep_delta_queue.
module sdq_cell (
    input  logic               i_clk,
    input  sdq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  sdq_pkg::t_entry    i_left,
    input  sdq_pkg::t_entry    i_right,
    input  sdq_pkg::t_entry    i_tok,
    output sdq_pkg::t_entry    o_entry,
    output sdq_pkg::t_entry    o_shift,
    output sdq_pkg::t_entry    o_tok,
    output logic               o_go
);
    import sdq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_entry r_tok;

    // Token passes on when this entry wakes no later than the new task
    assign o_go  = i_occ && (r_entry.delta <= r_tok.delta);
    assign o_tok = '{task_id: r_tok.task_id, delta: r_tok.delta - r_entry.delta};

    // Entry pushed right on insert; at the insert point it loses the token's ticks
    assign o_shift = i_ctl.here ?
                     '{task_id: r_entry.task_id, delta: r_entry.delta - r_tok.delta} :
                     r_entry;
    assign o_entry = r_entry;

    // Entry update
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            n_entry = r_tok;
        end else if (i_ctl.shift_r) begin
            n_entry = i_left;
        end else if (i_ctl.shift_l) begin
            n_entry = i_right;
        end else if (i_ctl.dec) begin
            n_entry.delta = r_entry.delta - DELTA_W'(1);
        end
    end

    // Payload only: no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_tok   <= i_tok;
    end

endmodule

// ===== hw/rtl/sleep_delta_queue.sv =====
// sleep_delta_queue: delta-list timer queue built as a chain of slot cells.
// Add: accepted when idle, then the token walks the chain slot by slot until it settles.
// Tick: taken when idle; woken tasks then leave one at a time through the output register.
// Full-queue add: one dropped result, loaded from the drop state once the output is free.
// Reset (synchronous, active low) empties the queue; slot contents stay unknown.
module sleep_delta_queue #(
    parameter int unsigned TASK_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdq_in_if.sink     i_in,
    sdq_out_if.source  o_out
);
    import sdq_pkg::*;

    localparam int unsigned POS_W = $clog2(TASK_SLOTS);
    localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT,
        S_DROP
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [POS_W-1:0]   r_pos;
    logic [TASK_W-1:0]  r_drop_task;
    logic               r_out_valid;
    logic [TASK_W-1:0]  r_out_task;
    logic               r_out_last;
    logic               r_out_drop;

    t_cell_ctl              w_ctl   [TASK_SLOTS];
    t_entry                 w_entry [TASK_SLOTS];
    t_entry                 w_shift [TASK_SLOTS];
    t_entry                 w_tok   [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]  w_go;
    logic                   w_go_sel;
    t_entry                 w_inject;
    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_full;
    logic                   w_walk;
    logic                   w_dec_head;
    logic                   w_emit_fire;
    logic                   w_emit_last;

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_in_xfer    = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_full       = (r_count == CNT_W'(TASK_SLOTS));
    assign w_walk       = (r_state == S_WALK);
    assign w_go_sel     = w_go[r_pos];
    assign w_emit_fire  = (r_state == S_EMIT) && w_out_free;
    assign w_out_load   = w_emit_fire || ((r_state == S_DROP) && w_out_free);
    assign w_emit_last  = (r_count == CNT_W'(1)) || (w_entry[1].delta != '0);
    assign w_dec_head   = w_in_xfer && (i_in.mode == MODE_TICK) && (r_count != '0)
                          && (w_entry[0].delta > DELTA_W'(1));

    // New token: a zero sleep counts as one tick
    assign w_inject.task_id = i_in.task_id;
    assign w_inject.delta   = (i_in.sleep_ticks == '0) ? DELTA_W'(1) : i_in.sleep_ticks;

    // Slot chain
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        t_entry w_tok_in;
        logic   w_occ;

        assign w_occ = (CNT_W'(g) < r_count);

        assign w_ctl[g].here    = w_walk && (r_pos == POS_W'(g));
        assign w_ctl[g].insert  = w_walk && (r_pos == POS_W'(g)) && !w_go_sel;
        assign w_ctl[g].shift_r = w_walk && !w_go_sel && (POS_W'(g) > r_pos);
        assign w_ctl[g].shift_l = w_emit_fire;
        assign w_ctl[g].dec     = (g == 0) && w_dec_head;

        if (g == 0) begin : g_first
            assign w_left   = w_shift[g];
            assign w_tok_in = w_inject;
        end else begin : g_mid
            assign w_left   = w_shift[g-1];
            assign w_tok_in = w_tok[g-1];
        end

        if (g == TASK_SLOTS - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_occ   (w_occ),
            .i_left  (w_left),
            .i_right (w_right),
            .i_tok   (w_tok_in),
            .o_entry (w_entry[g]),
            .o_shift (w_shift[g]),
            .o_tok   (w_tok[g]),
            .o_go    (w_go[g])
        );
    end

    // Sequencer, fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (i_in.mode == MODE_ADD) begin
                            r_drop_task <= i_in.task_id;
                            r_pos       <= '0;
                            r_state     <= w_full ? S_DROP : S_WALK;
                        end else if ((r_count != '0) &&
                                     (w_entry[0].delta <= DELTA_W'(1))) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_WALK: begin
                    if (w_go_sel) begin
                        r_pos <= r_pos + POS_W'(1);
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_task  <= w_entry[0].task_id;
                        r_out_last  <= w_emit_last;
                        r_out_drop  <= 1'b0;
                        r_count     <= r_count - CNT_W'(1);
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DROP: begin
                    if (w_out_free) begin
                        r_out_task  <= r_drop_task;
                        r_out_last  <= 1'b1;
                        r_out_drop  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.woken_task = r_out_task;
    assign o_out.last_woken = r_out_last;
    assign o_out.dropped    = r_out_drop;

endmodule

// ===== hw/rtl/sdq_checker.sv =====
// sdq_checker: port-level assertions for sleep_delta_queue, bound to the top level.
// Depends on sdq_pkg for field widths.
module sdq_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_ready,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [sdq_pkg::TASK_W-1:0] i_out_task,
    input  logic                      i_out_last,
    input  logic                      i_out_drop
);
    import sdq_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_task) && $stable(i_out_last) && $stable(i_out_drop))
        else $error("result payload changed while stalled");

    // A dropped add is always the single, final result of its transfer
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_drop |-> i_out_last)
        else $error("dropped result not marked last");

    // Mid-burst of woken tasks no new transfer is taken
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready during a wake burst");

endmodule

bind sleep_delta_queue sdq_checker u_sdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_task  (o_out.woken_task),
    .i_out_last  (o_out.last_woken),
    .i_out_drop  (o_out.dropped)
);

// ===== dv/testbench.sv =====
// testbench: self-checking bench for sleep_delta_queue (delta-list timer queue).
// Depends on sdq_pkg, sdq_in_if, sdq_out_if and the sleep_delta_queue RTL.
// Keeps a shadow queue in wake order and checks every woken or rejected task in order.
module testbench;
    import sdq_pkg::*;

    localparam int unsigned SLOTS      = 16;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned MAX_SHOWN  = 10;

    typedef struct packed {
        logic [TASK_W-1:0] woken_task;
        logic              last_woken;
        logic              dropped;
    } t_wake;

    logic clk;
    logic rst_n;

    sdq_in_if  in_ch ();
    sdq_out_if out_ch ();

    sleep_delta_queue #(
        .TASK_SLOTS (SLOTS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow delta list and the wakes still owed by the block
    logic [TASK_W-1:0]  shadow_task  [SLOTS];
    logic [DELTA_W-1:0] shadow_delta [SLOTS];
    int                 shadow_count;
    t_wake              pending_wakes [$];

    int  mismatches;
    int  idle_cycles;
    bit  in_idle_on;
    bit  out_idle_on;
    int  huge_sleeps_left;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Insert a task behind every task waking no later; full queue rejects it
    function void sleep_queue_add(input logic [TASK_W-1:0] id, input logic [DELTA_W-1:0] ticks);
        logic [DELTA_W-1:0] remain;
        int                 pos;
        int                 j;
        if (shadow_count >= SLOTS) begin
            pending_wakes.push_back('{woken_task: id, last_woken: 1'b1, dropped: 1'b1});
            return;
        end
        remain = (ticks == '0) ? 1 : ticks;
        pos = 0;
        while (pos < shadow_count && shadow_delta[pos] <= remain) begin
            remain = remain - shadow_delta[pos];
            pos++;
        end
        if (pos < shadow_count)
            shadow_delta[pos] = shadow_delta[pos] - remain;
        for (j = shadow_count; j > pos; j--) begin
            shadow_task[j]  = shadow_task[j-1];
            shadow_delta[j] = shadow_delta[j-1];
        end
        shadow_task[pos]  = id;
        shadow_delta[pos] = remain;
        shadow_count++;
    endfunction

    // Count the head down; when it runs out, wake it and every zero-delta follower
    function void sleep_queue_tick();
        int n;
        int j;
        if (shadow_count == 0)
            return;
        if (shadow_delta[0] != '0) begin
            shadow_delta[0] = shadow_delta[0] - 1;
            if (shadow_delta[0] != '0)
                return;
        end
        n = 1;
        while (n < shadow_count && shadow_delta[n] == '0)
            n++;
        for (j = 0; j < n; j++)
            pending_wakes.push_back('{woken_task: shadow_task[j],
                                      last_woken: (j == n - 1), dropped: 1'b0});
        for (j = n; j < shadow_count; j++) begin
            shadow_task[j-n]  = shadow_task[j];
            shadow_delta[j-n] = shadow_delta[j];
        end
        shadow_count = shadow_count - n;
    endfunction

    // Compare one result transfer with the oldest owed wake
    function void check_wake(input t_wake got);
        t_wake want;
        if (pending_wakes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("unexpected result: task %0d last %0b dropped %0b",
                         got.woken_task, got.last_woken, got.dropped);
            return;
        end
        want = pending_wakes.pop_front();
        if (got.woken_task !== want.woken_task || got.last_woken !== want.last_woken ||
            got.dropped !== want.dropped) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch: want task %0d last %0b drop %0b, got %0d %0b %0b",
                         want.woken_task, want.last_woken, want.dropped,
                         got.woken_task, got.last_woken, got.dropped);
        end
    endfunction

    // Transfers seen at the rising edge: check results, then predict from inputs
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_wake('{woken_task: out_ch.woken_task, last_woken: out_ch.last_woken,
                         dropped: out_ch.dropped});
        if (rst_n && in_ch.valid && in_ch.ready) begin
            if (in_ch.mode == MODE_ADD)
                sleep_queue_add(in_ch.task_id, in_ch.sleep_ticks);
            else
                sleep_queue_tick();
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random stall before each transfer, unless stalls are off
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            stall = out_idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // One input transfer; called and returns at a falling edge, valid left high
    task automatic send_item(input logic mode, input logic [TASK_W-1:0] id,
                             input logic [DELTA_W-1:0] ticks);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.task_id     <= id;
        in_ch.sleep_ticks <= ticks;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_task(input logic [TASK_W-1:0] id, input logic [DELTA_W-1:0] ticks);
        send_item(MODE_ADD, id, ticks);
    endtask

    // Tick payload is don't-care, so keep it random
    task automatic send_tick();
        send_item(MODE_TICK, TASK_W'($urandom_range(0, 15)), $urandom);
    endtask

    // Tick on an empty queue gives nothing
    task automatic test_empty_tick();
        send_tick();
    endtask

    // Zero sleep counts as one tick and shares the wake with an equal sleep, in arrival order
    task automatic test_zero_and_equal_sleep();
        add_task(4'd0, 32'd0);
        add_task(4'd15, 32'd1);
        send_tick();
    endtask

    // Longest sleep stays at the back; one tick wakes nothing, the next wakes a pair
    task automatic test_long_sleep();
        add_task(4'd5, 32'hFFFF_FFFF);
        add_task(4'd6, 32'd2);
        add_task(4'd7, 32'd2);
        send_tick();
        send_tick();
    endtask

    // Fill every slot, have one add rejected, then wake the whole short-sleep batch at once
    task automatic test_full_queue();
        int k;
        for (k = 0; k < SLOTS - 1; k++)
            add_task(k[TASK_W-1:0], (k % 2 == 0) ? 32'd1 : 32'd0);
        add_task(TASK_W'($urandom_range(0, 15)), $urandom_range(0, 9));
        send_tick();
    endtask

    // Mostly short sleeps so tasks keep waking; a few very long ones stay parked
    function automatic logic [DELTA_W-1:0] pick_sleep();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom_range(0, 4);
        if (pick < 85)
            return $urandom_range(0, 20);
        if (pick < 98 || huge_sleeps_left == 0)
            return $urandom_range(0, 60);
        huge_sleeps_left--;
        return $urandom;
    endfunction

    // Each phase picks at random an add share of 25, 55 or 85 percent and idling on each side
    task automatic test_random_mix(input int phases, input int items_per_phase);
        int phase;
        int k;
        int add_pct;
        for (phase = 0; phase < phases; phase++) begin
            case ($urandom_range(0, 2))
                0: add_pct = 25;
                1: add_pct = 55;
                default: add_pct = 85;
            endcase
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            for (k = 0; k < items_per_phase; k++) begin
                if ($urandom_range(0, 99) < add_pct)
                    add_task(TASK_W'($urandom_range(0, 15)), pick_sleep());
                else
                    send_tick();
            end
        end
    endtask

    // Test sequence
    initial begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_ADD;
        in_ch.task_id     = '0;
        in_ch.sleep_ticks = '0;
        shadow_count      = 0;
        mismatches        = 0;
        idle_cycles       = 0;
        in_idle_on        = 1'b1;
        out_idle_on       = 1'b1;
        huge_sleeps_left  = 3;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_tick();
        test_zero_and_equal_sleep();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_long_sleep();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        test_full_queue();
        test_random_mix(12, 40);

        in_ch.valid <= 1'b0;
        while (pending_wakes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_wakes.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_wakes.size());
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_in_if.sv
hw/rtl/sdq_out_if.sv
hw/rtl/sdq_cell.sv
hw/rtl/sleep_delta_queue.sv
hw/rtl/sdq_checker.sv
dv/testbench.sv
